/* rtl/dsu_pkg.sv */
`default_nettype none

package dsu_pkg;

    // fixed field widths
    localparam int ELEM_W  = 10;
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // sequencer step counter
    localparam int STEP_W = 4;
    localparam int STEPS  = 16;

    // walker source select
    localparam logic [2:0] CUR_HOLD  = 3'd0;
    localparam logic [2:0] CUR_IN_A  = 3'd1;
    localparam logic [2:0] CUR_A     = 3'd2;
    localparam logic [2:0] CUR_B     = 3'd3;
    localparam logic [2:0] CUR_RDATA = 3'd4;

    // store write select
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_PATH = 2'd1;
    localparam logic [1:0] WR_LINK = 2'd2;

    // jump conditions
    localparam logic [2:0] C_NEVER    = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_NO_ITEM  = 3'd2;
    localparam logic [2:0] C_BAD      = 3'd3;
    localparam logic [2:0] C_ROOT_HIT = 3'd4;
    localparam logic [2:0] C_AT_ROOT  = 3'd5;
    localparam logic [2:0] C_OUT_BUSY = 3'd6;

    // step addresses
    localparam logic [STEP_W-1:0] STEP_ACCEPT  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WALK_A  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_READ_A  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_RWND_A  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CMPR_A  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FIX_A   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SAVE_A  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_START_B = 4'd8;
    localparam logic [STEP_W-1:0] STEP_WALK_B  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_READ_B  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_RWND_B  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_CMPR_B  = 4'd12;
    localparam logic [STEP_W-1:0] STEP_FIX_B   = 4'd13;
    localparam logic [STEP_W-1:0] STEP_LINK    = 4'd14;
    localparam logic [STEP_W-1:0] STEP_FIN     = 4'd15;

    typedef struct packed {
        logic              rd;
        logic [1:0]        wr;
        logic [2:0]        cur_sel;
        logic              ld_root;
        logic              ld_ra;
        logic              ld_in;
        logic              ld_out;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ctl_word_t;

    // control store: rd, wr, cur_sel, ld_root, ld_ra, ld_in, ld_out, cond, target
    // the final step falls through by wrap of the step counter back to accept
    localparam ctl_word_t UCODE [STEPS] = '{
        '{1'b0, WR_NONE, CUR_IN_A,  1'b0, 1'b0, 1'b1, 1'b0, C_NO_ITEM,  STEP_ACCEPT},
        '{1'b1, WR_NONE, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b0, C_BAD,      STEP_FIN},
        '{1'b0, WR_NONE, CUR_RDATA, 1'b1, 1'b0, 1'b0, 1'b0, C_ROOT_HIT, STEP_RWND_A},
        '{1'b1, WR_NONE, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,   STEP_WALK_A},
        '{1'b0, WR_NONE, CUR_A,     1'b0, 1'b0, 1'b0, 1'b0, C_NEVER,    STEP_ACCEPT},
        '{1'b1, WR_NONE, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b0, C_AT_ROOT,  STEP_SAVE_A},
        '{1'b0, WR_PATH, CUR_RDATA, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,   STEP_CMPR_A},
        '{1'b0, WR_NONE, CUR_B,     1'b0, 1'b1, 1'b0, 1'b0, C_NEVER,    STEP_ACCEPT},
        '{1'b1, WR_NONE, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b0, C_NEVER,    STEP_ACCEPT},
        '{1'b0, WR_NONE, CUR_RDATA, 1'b1, 1'b0, 1'b0, 1'b0, C_ROOT_HIT, STEP_RWND_B},
        '{1'b1, WR_NONE, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,   STEP_WALK_B},
        '{1'b0, WR_NONE, CUR_B,     1'b0, 1'b0, 1'b0, 1'b0, C_NEVER,    STEP_ACCEPT},
        '{1'b1, WR_NONE, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b0, C_AT_ROOT,  STEP_LINK},
        '{1'b0, WR_PATH, CUR_RDATA, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,   STEP_CMPR_B},
        '{1'b0, WR_LINK, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b0, C_NEVER,    STEP_ACCEPT},
        '{1'b0, WR_NONE, CUR_HOLD,  1'b0, 1'b0, 1'b0, 1'b1, C_OUT_BUSY, STEP_FIN}
    };

endpackage

`default_nettype wire

/* rtl/disjoint_set_union_find.sv */
`default_nettype none

// channel   | handshake                | payload
// ----------+--------------------------+---------------------------
// in        | in_valid / in_stall      | cmd, elem_a, elem_b
// out       | out_valid / out_stall    | same_set, bad_index
// cfg       | cfg_valid / cfg_ready    | cfg_data (element count)
//
// one transaction at a time, run by a 16-step control store over one
// single-port parent memory with a registered read port.
// when indices are good both a and b are walked to their roots; a flagged
// index jumps from the check to the final step, which an output stall holds.
// after reset a clearing pass writes each entry with its own index while
// in_stall is held high; cfg writes are taken throughout.
// a held result does not block the next transaction until its final step.
module disjoint_set_union_find
    import dsu_pkg::*;
#(
    parameter int ELEMENTS = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic [ELEM_W-1:0]  elem_a,
    input  wire logic [ELEM_W-1:0]  elem_b,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    same_set,
    output logic                    bad_index,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    localparam int IDX_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int EXT_W = ELEM_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);

    // control state
    logic [STEP_W-1:0]  pc_reg, pc_next;
    logic               clr_busy_reg;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;

    // datapath registers
    logic               cmd_reg;
    logic               bad_reg;
    logic [IDX_W-1:0]   a_reg;
    logic [IDX_W-1:0]   b_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   root_reg;
    logic [IDX_W-1:0]   ra_reg;
    logic [IDX_W-1:0]   rdata_reg;
    logic               same_reg;
    logic               bad_out_reg;

    logic [IDX_W-1:0]   parent_mem [ELEMENTS];

    ctl_word_t          ctl;
    logic               in_acc;
    logic               out_busy;
    logic               take;
    logic               in_bad;
    logic [EXT_W-1:0]   a_ext;
    logic [EXT_W-1:0]   b_ext;
    logic [IDX_W-1:0]   a_idx;
    logic [IDX_W-1:0]   b_idx;
    logic [IDX_W-1:0]   cur_next;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   wr_data;

    // handshakes
    assign ctl       = UCODE[pc_reg];
    assign in_stall  = !(pc_reg == STEP_ACCEPT && !clr_busy_reg);
    assign in_acc    = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign same_set  = same_reg;
    assign bad_index = bad_out_reg;
    assign cfg_ready = 1'b1;

    // index check and narrowing to the store width
    assign in_bad = ({1'b0, elem_a} >= count_reg) || ({1'b0, elem_b} >= count_reg)
                    || (elem_a >= ELEMENTS) || (elem_b >= ELEMENTS);
    assign a_ext  = {{IDX_W{1'b0}}, elem_a};
    assign b_ext  = {{IDX_W{1'b0}}, elem_b};
    assign a_idx  = a_ext[IDX_W-1:0];
    assign b_idx  = b_ext[IDX_W-1:0];

    // jump condition
    always_comb
    begin
        unique case (ctl.cond)
            C_ALWAYS:   take = 1'b1;
            C_NO_ITEM:  take = !in_acc;
            C_BAD:      take = bad_reg;
            C_ROOT_HIT: take = (rdata_reg == cur_reg);
            C_AT_ROOT:  take = (cur_reg == root_reg);
            C_OUT_BUSY: take = out_busy;
            default:    take = 1'b0;
        endcase
        pc_next = take ? ctl.target : pc_reg + 1'b1;
    end

    // walker source
    always_comb
    begin
        unique case (ctl.cur_sel)
            CUR_IN_A:  cur_next = a_idx;
            CUR_A:     cur_next = a_reg;
            CUR_B:     cur_next = b_reg;
            CUR_RDATA: cur_next = rdata_reg;
            default:   cur_next = cur_reg;
        endcase
    end

    // store write port: clearing pass, path fix or merge link
    always_comb
    begin
        priority if (clr_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = clr_idx_reg;
        end
        else if (ctl.wr == WR_PATH)
        begin
            wr_en   = 1'b1;
            wr_addr = cur_reg;
            wr_data = root_reg;
        end
        else if (ctl.wr == WR_LINK)
        begin
            wr_en   = !cmd_reg;
            wr_addr = ra_reg;
            wr_data = root_reg;
        end
        else
        begin
            wr_en   = 1'b0;
            wr_addr = cur_reg;
            wr_data = root_reg;
        end
    end

    // parent memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parent_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rdata_reg <= parent_mem[cur_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_ACCEPT;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg  <= clr_idx_reg + 1'b1;
                clr_busy_reg <= (clr_idx_reg != LAST_IDX);
            end
            else
            begin
                pc_reg <= pc_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (ctl.ld_out && !out_busy && !clr_busy_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.ld_in && in_acc)
        begin
            cmd_reg <= cmd;
            bad_reg <= in_bad;
            a_reg   <= a_idx;
            b_reg   <= b_idx;
        end
        if (!clr_busy_reg)
        begin
            cur_reg <= cur_next;
        end
        if (ctl.ld_root)
        begin
            root_reg <= rdata_reg;
        end
        if (ctl.ld_ra)
        begin
            ra_reg <= root_reg;
        end
        if (ctl.ld_out && !out_busy && !clr_busy_reg)
        begin
            same_reg    <= !bad_reg && cmd_reg && (ra_reg == root_reg);
            bad_out_reg <= bad_reg;
        end
    end

    // a result appears only after the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg) == STEP_FIN)
        else $error("result raised outside final step");

    // sequencer stays parked while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> pc_reg == STEP_ACCEPT)
        else $error("sequencer moved during clearing pass");

    // a flagged item never reports a shared root
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(same_reg && bad_out_reg))
        else $error("flagged result reports same set");

    // a waiting result is not overwritten by the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && pc_reg == STEP_FIN) |=> pc_reg == STEP_FIN)
        else $error("sequencer left final step while output held");

endmodule

`default_nettype wire
